// File: rtl/motor_feedback_angle_tracker_defines.svh
// assertion macros used by the checker file
// each macro expects clk and arst_n in the scope where it is used
`ifndef MOTOR_FEEDBACK_ANGLE_TRACKER_DEFINES_SVH
`define MOTOR_FEEDBACK_ANGLE_TRACKER_DEFINES_SVH

// same-cycle implication
`define MFAT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication
`define MFAT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// File: rtl/mfat_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mfat_pkg;

	// encoder geometry
	localparam int ENCODER_COUNTS = 8192;
	localparam int CNT_W          = $clog2(ENCODER_COUNTS);
	localparam int DELTA_W        = CNT_W + 1;

	// field and register widths
	localparam int ID_W    = 11;
	localparam int SCALE_W = 20;
	localparam int ANGLE_W = 25;
	localparam int DATA_W  = 32;
	localparam int PADDR_W = 4;

	// scaling arithmetic
	localparam int PROD_W    = DELTA_W + SCALE_W + 1;
	localparam int FRAC_DROP = 8;
	localparam int SCALED_W  = PROD_W - FRAC_DROP;
	localparam int SUM_W     = SCALED_W + 1;

	// queue sizes
	localparam int MID_DEPTH = 4;
	localparam int MID_PTR_W = $clog2(MID_DEPTH);
	localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);
	localparam int OUT_DEPTH = 4;
	localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

	// register reset values
	localparam logic [ID_W-1:0]    RX_ID_RESET  = ID_W'(517);
	localparam logic [SCALE_W-1:0] SCALE_RESET  = SCALE_W'(737280);
	localparam logic               ENABLE_RESET = 1'b1;

	// constants of the tracking math
	localparam logic signed [DELTA_W-1:0] COUNTS_D    = DELTA_W'(ENCODER_COUNTS);
	localparam logic signed [DELTA_W-1:0] HALF_COUNTS = DELTA_W'(ENCODER_COUNTS / 2);
	localparam logic signed [PROD_W-1:0]  ROUND_BIAS  = PROD_W'(1 << (FRAC_DROP - 1));
	localparam logic signed [SUM_W-1:0]   HALF_TURN   = SUM_W'(180 * 65536);
	localparam logic signed [SUM_W-1:0]   FULL_TURN   = SUM_W'(360 * 65536);

	// register map
	typedef enum logic [1:0] {
		REG_RX_ID  = 2'd0,
		REG_SCALE  = 2'd1,
		REG_ENABLE = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [ID_W-1:0]    rx_id;
		logic [SCALE_W-1:0] scale;
		logic               enable;
	} cfg_t;

	typedef struct packed {
		logic [7:0]         temperature;
		logic [15:0]        encoder_raw;
		logic signed [15:0] speed;
		logic signed [15:0] drive_current;
	} fb_fields_t;

	// one classified frame on its way to the back end
	typedef struct packed {
		fb_fields_t                 fields;
		logic signed [DELTA_W-1:0]  delta;
		logic                       first;
		logic                       track;
	} mid_entry_t;

endpackage

`default_nettype wire

// File: rtl/mfat_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module mfat_queue
	import mfat_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire mid_entry_t push_data,
	output logic            full,
	input  wire logic       pop,
	output mid_entry_t      pop_data,
	output logic            empty
);

	mid_entry_t             mem_q [MID_DEPTH];
	logic [MID_PTR_W-1:0]   wr_ptr_q;
	logic [MID_PTR_W-1:0]   rd_ptr_q;
	logic [MID_CNT_W-1:0]   count_q;
	logic                   do_push;
	logic                   do_pop;

	assign full     = (count_q == MID_CNT_W'(MID_DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!do_push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// File: rtl/mfat_front.sv
`timescale 1ns / 1ps
`default_nettype none

module mfat_front
	import mfat_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire cfg_t            cfg,
	input  wire logic            push,
	output logic                 full,
	input  wire logic [ID_W-1:0] frame_id,
	input  wire logic [7:0]      rx_byte0,
	input  wire logic [7:0]      rx_byte1,
	input  wire logic [7:0]      rx_byte2,
	input  wire logic [7:0]      rx_byte3,
	input  wire logic [7:0]      rx_byte4,
	input  wire logic [7:0]      rx_byte5,
	input  wire logic [7:0]      rx_byte6,
	output logic                 q_push,
	output mid_entry_t           q_data,
	input  wire logic            q_full
);

	logic [CNT_W-1:0]          prev_count_q;
	logic                      seen_q;
	logic                      accept;
	logic                      match;
	logic [15:0]               encoder;
	logic [CNT_W-1:0]          count;
	logic signed [DELTA_W-1:0] diff;
	logic signed [DELTA_W-1:0] rolled;

	assign full   = q_full;
	assign accept = push && !q_full;
	assign match  = (frame_id == cfg.rx_id);
	assign q_push = accept && match;

	assign encoder = {rx_byte0, rx_byte1};
	assign count   = encoder[CNT_W-1:0];

	// raw count difference, then rollover correction by one turn of the encoder
	always_comb begin
		diff = $signed({1'b0, count}) - $signed({1'b0, prev_count_q});
		if (diff > HALF_COUNTS) begin
			rolled = diff - COUNTS_D;
		end else if (diff < -HALF_COUNTS) begin
			rolled = diff + COUNTS_D;
		end else begin
			rolled = diff;
		end
	end

	// classified entry; the first tracked frame carries the absolute count
	always_comb begin
		q_data.fields.temperature   = rx_byte6;
		q_data.fields.encoder_raw   = encoder;
		q_data.fields.speed         = $signed({rx_byte2, rx_byte3});
		q_data.fields.drive_current = $signed({rx_byte4, rx_byte5});
		q_data.first                = !seen_q;
		q_data.track                = cfg.enable;
		q_data.delta                = seen_q ? rolled : $signed({1'b0, count});
	end

	// last tracked count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_count_q <= '0;
			seen_q       <= 1'b0;
		end else if (q_push && cfg.enable) begin
			prev_count_q <= count;
			seen_q       <= 1'b1;
		end
	end

endmodule

`default_nettype wire

// File: rtl/mfat_back.sv
`timescale 1ns / 1ps
`default_nettype none

module mfat_back
	import mfat_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cfg_t               cfg,
	input  wire logic               q_empty,
	output logic                    q_pop,
	input  wire mid_entry_t         q_data,
	output logic                    empty,
	input  wire logic               pop,
	output logic [7:0]              temperature,
	output logic [15:0]             encoder_raw,
	output logic signed [15:0]      speed,
	output logic signed [15:0]      drive_current,
	output logic signed [ANGLE_W-1:0] shaft_angle
);

	// multiply stage
	logic                       valid_s1;
	fb_fields_t                 fields_s1;
	logic                       first_s1;
	logic                       track_s1;
	logic signed [SCALED_W-1:0] scaled_s1;
	logic signed [PROD_W-1:0]   delta_ext;
	logic signed [PROD_W-1:0]   scale_ext;
	logic signed [PROD_W-1:0]   prod;
	logic signed [PROD_W-1:0]   rounded;

	// accumulate stage
	logic signed [ANGLE_W-1:0]  acc_q;
	logic signed [SUM_W-1:0]    base;
	logic signed [SUM_W-1:0]    sum;
	logic signed [SUM_W-1:0]    wrapped;
	logic signed [ANGLE_W-1:0]  new_angle;

	// result queue
	fb_fields_t                 out_fields_q [OUT_DEPTH];
	logic signed [ANGLE_W-1:0]  out_angle_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0]       out_wr_q;
	logic [OUT_PTR_W-1:0]       out_rd_q;
	logic [OUT_CNT_W-1:0]       out_cnt_q;
	logic [OUT_CNT_W-1:0]       committed;
	logic                       out_pop;

	// take an entry only when the result queue has room for everything in flight
	assign committed = out_cnt_q + OUT_CNT_W'(valid_s1);
	assign q_pop     = !q_empty && (committed < OUT_CNT_W'(OUT_DEPTH));

	// count delta times scale, rounded to nearest at 16 fraction bits
	assign delta_ext = PROD_W'(q_data.delta);
	assign scale_ext = $signed(PROD_W'(cfg.scale));
	assign prod      = delta_ext * scale_ext;
	assign rounded   = prod + ROUND_BIAS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= q_pop;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			fields_s1 <= q_data.fields;
			first_s1  <= q_data.first;
			track_s1  <= q_data.track;
			scaled_s1 <= rounded[PROD_W-1:FRAC_DROP];
		end
	end

	// accumulate and fold back into one half turn either side
	always_comb begin
		base = first_s1 ? '0 : SUM_W'(acc_q);
		sum  = base + SUM_W'(scaled_s1);
		if (sum > HALF_TURN) begin
			wrapped = sum - FULL_TURN;
		end else if (sum < -HALF_TURN) begin
			wrapped = sum + FULL_TURN;
		end else begin
			wrapped = sum;
		end
		new_angle = track_s1 ? wrapped[ANGLE_W-1:0] : acc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (valid_s1) begin
			acc_q <= new_angle;
		end
	end

	// result queue control
	assign empty   = (out_cnt_q == '0);
	assign out_pop = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_wr_q  <= '0;
			out_rd_q  <= '0;
			out_cnt_q <= '0;
		end else begin
			if (valid_s1) begin
				out_wr_q <= out_wr_q + 1'b1;
			end
			if (out_pop) begin
				out_rd_q <= out_rd_q + 1'b1;
			end
			if (valid_s1 && !out_pop) begin
				out_cnt_q <= out_cnt_q + 1'b1;
			end else if (!valid_s1 && out_pop) begin
				out_cnt_q <= out_cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			out_fields_q[out_wr_q] <= fields_s1;
			out_angle_q[out_wr_q]  <= new_angle;
		end
	end

	// head of the result queue
	assign temperature   = out_fields_q[out_rd_q].temperature;
	assign encoder_raw   = out_fields_q[out_rd_q].encoder_raw;
	assign speed         = out_fields_q[out_rd_q].speed;
	assign drive_current = out_fields_q[out_rd_q].drive_current;
	assign shaft_angle   = out_angle_q[out_rd_q];

endmodule

`default_nettype wire

// File: rtl/motor_feedback_angle_tracker.sv
// Motor feedback angle tracker: decodes received feedback frames for one motor.
// Input channel: push a frame (frame_id, rx_byte0..rx_byte6) while full is low.
// Frames whose identifier differs from rx_identifier are taken and dropped.
// Result channel: while empty is low the oldest result sits on temperature,
// encoder_raw, speed, drive_current and shaft_angle; pop takes it.
// Configuration: APB writes at byte addresses 0 (rx_identifier), 4 (angle_scale)
// and 8 (angle_enable), only while no frame is in flight.
// Path: a matching frame passes the middle queue, the multiply stage and the
// accumulate stage into the result queue before it can be popped.
// Throughput: one frame per cycle while full is low; the angle accumulator
// closes its loop through one add and one turn correction per cycle.
// Reset: registers return to their defaults, both queues empty, the tracked
// angle is zero and the next tracked frame sets the absolute angle.
// Stall: when pop stays low the result queue fills, then the middle queue,
// and full rises; nothing is dropped.
`timescale 1ns / 1ps
`default_nettype none

module motor_feedback_angle_tracker
	import mfat_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [PADDR_W-1:0]   paddr,
	input  wire logic [DATA_W-1:0]    pwdata,
	output logic [DATA_W-1:0]         prdata,
	output logic                      pready,
	input  wire logic                 push,
	output logic                      full,
	input  wire logic [ID_W-1:0]      frame_id,
	input  wire logic [7:0]           rx_byte0,
	input  wire logic [7:0]           rx_byte1,
	input  wire logic [7:0]           rx_byte2,
	input  wire logic [7:0]           rx_byte3,
	input  wire logic [7:0]           rx_byte4,
	input  wire logic [7:0]           rx_byte5,
	input  wire logic [7:0]           rx_byte6,
	output logic                      empty,
	input  wire logic                 pop,
	output logic [7:0]                temperature,
	output logic [15:0]               encoder_raw,
	output logic signed [15:0]        speed,
	output logic signed [15:0]        drive_current,
	output logic signed [ANGLE_W-1:0] shaft_angle
);

	logic [ID_W-1:0]    rx_id_q;
	logic [SCALE_W-1:0] scale_q;
	logic               enable_q;
	cfg_t               cfg;
	reg_idx_t           reg_idx;
	logic               wr_en;
	logic               q_push;
	logic               q_full;
	logic               q_pop;
	logic               q_empty;
	mid_entry_t         q_wdata;
	mid_entry_t         q_rdata;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign wr_en   = psel && penable && pwrite && pready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_id_q  <= RX_ID_RESET;
			scale_q  <= SCALE_RESET;
			enable_q <= ENABLE_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_RX_ID:  rx_id_q  <= pwdata[ID_W-1:0];
				REG_SCALE:  scale_q  <= pwdata[SCALE_W-1:0];
				REG_ENABLE: enable_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (reg_idx)
			REG_RX_ID:  prdata = DATA_W'(rx_id_q);
			REG_SCALE:  prdata = DATA_W'(scale_q);
			REG_ENABLE: prdata = DATA_W'(enable_q);
			default:    prdata = '0;
		endcase
	end

	assign cfg.rx_id  = rx_id_q;
	assign cfg.scale  = scale_q;
	assign cfg.enable = enable_q;

	mfat_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.push     (push),
		.full     (full),
		.frame_id (frame_id),
		.rx_byte0 (rx_byte0),
		.rx_byte1 (rx_byte1),
		.rx_byte2 (rx_byte2),
		.rx_byte3 (rx_byte3),
		.rx_byte4 (rx_byte4),
		.rx_byte5 (rx_byte5),
		.rx_byte6 (rx_byte6),
		.q_push   (q_push),
		.q_data   (q_wdata),
		.q_full   (q_full)
	);

	mfat_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.empty     (q_empty)
	);

	mfat_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.q_empty       (q_empty),
		.q_pop         (q_pop),
		.q_data        (q_rdata),
		.empty         (empty),
		.pop           (pop),
		.temperature   (temperature),
		.encoder_raw   (encoder_raw),
		.speed         (speed),
		.drive_current (drive_current),
		.shaft_angle   (shaft_angle)
	);

endmodule

`default_nettype wire

// File: rtl/mfat_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "motor_feedback_angle_tracker_defines.svh"

module mfat_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               full,
	input wire logic               empty,
	input wire logic               pop,
	input wire logic [7:0]         temperature,
	input wire logic [15:0]        encoder_raw,
	input wire logic signed [24:0] shaft_angle
);

	// a waiting result holds until it is transferred
	`MFAT_ASSERT_NEXT(a_result_hold, !empty && !pop, !empty && $stable(shaft_angle) && $stable(temperature) && $stable(encoder_raw))

	// tracked angle stays within half a turn either side
	`MFAT_ASSERT_IMP(a_angle_range, !empty, (shaft_angle <= 25'sd11796480) && (shaft_angle >= -25'sd11796480))

	// input can only back up behind waiting results
	`MFAT_ASSERT_IMP(a_full_backup, full, !empty)

endmodule

bind motor_feedback_angle_tracker mfat_checker u_mfat_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.full        (full),
	.empty       (empty),
	.pop         (pop),
	.temperature (temperature),
	.encoder_raw (encoder_raw),
	.shaft_angle (shaft_angle)
);

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import mfat_pkg::*;

	localparam int CLK_HALF      = 10;
	localparam int RESET_CYCLES  = 3;
	localparam int DRAIN_CYCLES  = 8;
	localparam int HOLD_CYCLES   = 60;
	localparam int RANDOM_FRAMES = 1100;
	localparam int PHASES        = 11;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int REPORT_LIMIT  = 10;

	// register index with nothing behind it
	localparam logic [1:0] REG_UNMAPPED = 2'd3;

	localparam longint COUNTS  = ENCODER_COUNTS;
	localparam longint DEG180  = 180 * 65536;
	localparam longint DEG360  = 360 * 65536;
	localparam logic [SCALE_W-1:0] SCALE_MAX = '1;

	typedef enum {ROW_FRAME, ROW_REG} row_kind_t;

	typedef struct packed {
		logic [ID_W-1:0] id;
		logic [15:0]     encoder;
		logic [15:0]     velocity;
		logic [15:0]     current;
		logic [7:0]      temp;
	} frame_t;

	typedef struct packed {
		fb_fields_t                 fields;
		logic signed [ANGLE_W-1:0]  angle;
	} feedback_t;

	typedef struct {
		row_kind_t        kind;
		frame_t           frame;
		logic [1:0]       reg_index;
		logic [DATA_W-1:0] reg_value;
		bit               angle_given;
		longint           angle;
	} row_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      psel = 1'b0;
	logic                      penable = 1'b0;
	logic                      pwrite = 1'b0;
	logic [PADDR_W-1:0]        paddr = '0;
	logic [DATA_W-1:0]         pwdata = '0;
	logic [DATA_W-1:0]         prdata;
	logic                      pready;
	logic                      push = 1'b0;
	logic                      full;
	logic [ID_W-1:0]           frame_id = '0;
	logic [7:0]                rx_byte0 = '0;
	logic [7:0]                rx_byte1 = '0;
	logic [7:0]                rx_byte2 = '0;
	logic [7:0]                rx_byte3 = '0;
	logic [7:0]                rx_byte4 = '0;
	logic [7:0]                rx_byte5 = '0;
	logic [7:0]                rx_byte6 = '0;
	logic                      empty;
	logic                      pop = 1'b0;
	logic [7:0]                temperature;
	logic [15:0]               encoder_raw;
	logic signed [15:0]        speed;
	logic signed [15:0]        drive_current;
	logic signed [ANGLE_W-1:0] shaft_angle;

	// tracker copy: configuration and state
	logic [ID_W-1:0]    cfg_rx_id;
	logic [SCALE_W-1:0] cfg_scale;
	logic               cfg_enable;
	longint             trk_prev_count = 0;
	longint             trk_angle = 0;
	bit                 trk_seen = 1'b0;

	feedback_t pending_feedback[$];
	int        mismatch_count = 0;
	int        cycle_count = 0;
	int        send_idle_pct = 0;
	int        recv_idle_pct = 0;
	int        hold_requests = 0;
	int        hold_served = 0;
	int        hold_left = 0;

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	motor_feedback_angle_tracker DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.push          (push),
		.full          (full),
		.frame_id      (frame_id),
		.rx_byte0      (rx_byte0),
		.rx_byte1      (rx_byte1),
		.rx_byte2      (rx_byte2),
		.rx_byte3      (rx_byte3),
		.rx_byte4      (rx_byte4),
		.rx_byte5      (rx_byte5),
		.rx_byte6      (rx_byte6),
		.empty         (empty),
		.pop           (pop),
		.temperature   (temperature),
		.encoder_raw   (encoder_raw),
		.speed         (speed),
		.drive_current (drive_current),
		.shaft_angle   (shaft_angle)
	);

	// count times scale (24 fraction bits) rounded to nearest at 16 fraction bits
	function automatic longint scaled_counts(input longint counts);
		return (counts * longint'(cfg_scale) + 128) >>> 8;
	endfunction

	// decode one frame and advance the tracked angle; 0 when the frame is dropped
	function automatic bit track_frame(input frame_t f, output feedback_t r);
		longint count;
		longint delta;
		r = '0;
		if (f.id != cfg_rx_id)
			return 1'b0;
		count = longint'(f.encoder) % COUNTS;
		if (cfg_enable) begin
			if (!trk_seen) begin
				trk_angle = scaled_counts(count);
				trk_seen = 1'b1;
			end else begin
				delta = count - trk_prev_count;
				// take the short way around the encoder rollover
				if (2 * delta > COUNTS)
					delta -= COUNTS;
				else if (2 * delta < -COUNTS)
					delta += COUNTS;
				trk_angle += scaled_counts(delta);
			end
			trk_prev_count = count;
			while (trk_angle > DEG180)
				trk_angle -= DEG360;
			while (trk_angle < -DEG180)
				trk_angle += DEG360;
		end
		r.fields.temperature = f.temp;
		r.fields.encoder_raw = f.encoder;
		r.fields.speed = f.velocity;
		r.fields.drive_current = f.current;
		r.angle = trk_angle[ANGLE_W-1:0];
		return 1'b1;
	endfunction

	function automatic row_t frame_row(input logic [ID_W-1:0] id, input logic [15:0] enc,
			input logic [15:0] vel, input logic [15:0] cur, input logic [7:0] temp,
			input bit given, input longint angle);
		row_t r;
		r.kind = ROW_FRAME;
		r.frame.id = id;
		r.frame.encoder = enc;
		r.frame.velocity = vel;
		r.frame.current = cur;
		r.frame.temp = temp;
		r.reg_index = '0;
		r.reg_value = '0;
		r.angle_given = given;
		r.angle = angle;
		return r;
	endfunction

	function automatic row_t reg_row(input logic [1:0] index, input logic [DATA_W-1:0] value);
		row_t r;
		r.kind = ROW_REG;
		r.frame = '0;
		r.reg_index = index;
		r.reg_value = value;
		r.angle_given = 1'b0;
		r.angle = 0;
		return r;
	endfunction

	task automatic flag_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("mismatch: %s", msg);
	endtask

	// offer one frame until it is taken, then record what it should produce
	task automatic offer_frame(input frame_t f, input bit angle_given, input longint angle);
		feedback_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		frame_id <= f.id;
		rx_byte0 <= f.encoder[15:8];
		rx_byte1 <= f.encoder[7:0];
		rx_byte2 <= f.velocity[15:8];
		rx_byte3 <= f.velocity[7:0];
		rx_byte4 <= f.current[15:8];
		rx_byte5 <= f.current[7:0];
		rx_byte6 <= f.temp;
		@(posedge clk);
		while (full)
			@(posedge clk);
		if (track_frame(f, r)) begin
			if (angle_given)
				r.angle = angle[ANGLE_W-1:0];
			pending_feedback.push_back(r);
		end
	endtask

	// stop offering and let everything in flight drain out
	task automatic wait_idle();
		push <= 1'b0;
		@(posedge clk);
		while (pending_feedback.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// setup and access phase of one register write
	task automatic write_register(input logic [1:0] index, input logic [DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'({index, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (index)
			REG_RX_ID: cfg_rx_id = value[ID_W-1:0];
			REG_SCALE: cfg_scale = value[SCALE_W-1:0];
			REG_ENABLE: cfg_enable = value[0];
			default: ;
		endcase
	endtask

	// result side: check each transfer, pop at random, long hold on request
	always @(posedge clk) begin
		feedback_t want;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (pending_feedback.size() == 0) begin
					flag_mismatch($sformatf("result with no frame pending, encoder_raw %0d",
						encoder_raw));
				end else begin
					want = pending_feedback.pop_front();
					if (temperature !== want.fields.temperature)
						flag_mismatch($sformatf("temperature expected %0d got %0d",
							want.fields.temperature, temperature));
					if (encoder_raw !== want.fields.encoder_raw)
						flag_mismatch($sformatf("encoder_raw expected %0d got %0d",
							want.fields.encoder_raw, encoder_raw));
					if (speed !== want.fields.speed)
						flag_mismatch($sformatf("speed expected %0d got %0d",
							want.fields.speed, speed));
					if (drive_current !== want.fields.drive_current)
						flag_mismatch($sformatf("drive_current expected %0d got %0d",
							want.fields.drive_current, drive_current));
					if (shaft_angle !== want.angle)
						flag_mismatch($sformatf("shaft_angle expected %0d got %0d",
							want.angle, shaft_angle));
				end
			end
			if (hold_served != hold_requests) begin
				hold_served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		row_t               rows[$];
		frame_t             f;
		logic [ID_W-1:0]    new_id;
		logic [SCALE_W-1:0] new_scale;
		logic               new_enable;
		int                 phase;
		int                 n;
		int                 sel;
		int                 cnt;
		int                 step;
		int                 enc_prev;

		cfg_rx_id = RX_ID_RESET;
		cfg_scale = SCALE_RESET;
		cfg_enable = ENABLE_RESET;
		enc_prev = 0;

		// directed frames; at the reset scale one count is exactly 2880 in angle units
		rows.push_back(frame_row(RX_ID_RESET, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1, 0));
		rows.push_back(frame_row(11'd516, 16'h1234, 16'h5678, 16'h9abc, 8'h11, 0, 0));
		rows.push_back(frame_row(RX_ID_RESET, 16'h1000, 16'h7fff, 16'h7fff, 8'hff, 1, 11796480));
		// one count past a half turn wraps to the negative side
		rows.push_back(frame_row(RX_ID_RESET, 16'h1001, 16'h8000, 16'h8000, 8'h80, 1, -11793600));
		rows.push_back(frame_row(RX_ID_RESET, 16'h0000, 16'hffff, 16'hffff, 8'h01, 1, 0));
		rows.push_back(frame_row(RX_ID_RESET, 16'hffff, 16'h0001, 16'h0001, 8'h7f, 1, -2880));
		rows.push_back(frame_row(11'h7ff, 16'h0100, 16'h0000, 16'h0000, 8'h00, 0, 0));
		rows.push_back(frame_row(11'h000, 16'h0200, 16'h0000, 16'h0000, 8'h00, 0, 0));
		// encoder words above the count range fold back into it
		rows.push_back(frame_row(RX_ID_RESET, 16'h2000, 16'h00ff, 16'hff00, 8'h55, 1, 0));
		rows.push_back(frame_row(RX_ID_RESET, 16'he001, 16'haaaa, 16'h5555, 8'haa, 1, 2880));
		// tracking off holds the angle
		rows.push_back(reg_row(REG_ENABLE, 32'd0));
		rows.push_back(frame_row(RX_ID_RESET, 16'h1234, 16'h0000, 16'h0000, 8'h00, 1, 2880));
		rows.push_back(frame_row(RX_ID_RESET, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1, 2880));
		rows.push_back(reg_row(REG_ENABLE, 32'd1));
		rows.push_back(frame_row(RX_ID_RESET, 16'h0002, 16'h0000, 16'h0000, 8'h00, 1, 5760));
		// write to an unmapped register is dropped
		rows.push_back(reg_row(REG_UNMAPPED, 32'hffff_ffff));
		rows.push_back(reg_row(REG_RX_ID, 32'd0));
		rows.push_back(frame_row(RX_ID_RESET, 16'h0003, 16'h0000, 16'h0000, 8'h00, 0, 0));
		rows.push_back(frame_row(11'h000, 16'h0003, 16'h0000, 16'h0000, 8'h00, 1, 8640));
		rows.push_back(reg_row(REG_RX_ID, 32'h7ff));
		rows.push_back(frame_row(11'h7ff, 16'h0004, 16'h0000, 16'h0000, 8'h00, 1, 11520));
		rows.push_back(reg_row(REG_SCALE, 32'd0));
		rows.push_back(frame_row(11'h7ff, 16'h1000, 16'h0000, 16'h0000, 8'h00, 1, 11520));
		rows.push_back(reg_row(REG_SCALE, 32'(SCALE_MAX)));
		rows.push_back(frame_row(11'h7ff, 16'h0000, 16'h1111, 16'h2222, 8'h33, 0, 0));
		rows.push_back(frame_row(11'h7ff, 16'h1000, 16'h4444, 16'h5555, 8'h66, 0, 0));

		// reset
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct <= 10;
		recv_idle_pct <= 80;
		foreach (rows[i]) begin
			if (rows[i].kind == ROW_FRAME) begin
				offer_frame(rows[i].frame, rows[i].angle_given, rows[i].angle);
			end else begin
				wait_idle();
				write_register(rows[i].reg_index, rows[i].reg_value);
			end
		end

		// random phases, each with its own register setting
		for (phase = 0; phase < PHASES; phase++) begin
			if (phase < 4) begin
				send_idle_pct <= 10;
				recv_idle_pct <= 80;
			end else if (phase < 8) begin
				send_idle_pct <= 80;
				recv_idle_pct <= 10;
			end else begin
				send_idle_pct <= 0;
				recv_idle_pct <= 0;
			end
			wait_idle();

			if (phase == 0) begin
				new_id = RX_ID_RESET;
			end else begin
				case ($urandom_range(3))
					0: new_id = '0;
					1: new_id = '1;
					default: new_id = ID_W'($urandom);
				endcase
			end
			case (phase % 5)
				0: new_scale = SCALE_RESET;
				1: new_scale = '0;
				2: new_scale = SCALE_MAX;
				3: new_scale = SCALE_W'($urandom_range(737280));
				default: new_scale = SCALE_W'($urandom);
			endcase
			new_enable = (phase == 3 || phase == 6) ? 1'b0 : 1'b1;

			// upper bits of each write carry noise
			write_register(REG_RX_ID, (32'($urandom) << ID_W) | 32'(new_id));
			write_register(REG_SCALE, (32'($urandom) << SCALE_W) | 32'(new_scale));
			write_register(REG_ENABLE, (32'($urandom) << 1) | 32'(new_enable));

			// receiver backs off for a while so the block fills up
			if (phase == 0 || phase == 8)
				hold_requests <= hold_requests + 1;

			for (n = 0; n < RANDOM_FRAMES / PHASES; n++) begin
				f.id = ($urandom_range(99) < 85) ? cfg_rx_id : ID_W'($urandom);
				sel = $urandom_range(99);
				if (sel < 55) begin
					// small motion from the last position
					step = int'($urandom_range(600)) - 300;
					cnt = (enc_prev + step) & 8191;
				end else if (sel < 70) begin
					// steps around half a turn
					step = int'($urandom_range(4098, 4094));
					if ($urandom_range(1))
						step = -step;
					cnt = (enc_prev + step) & 8191;
				end else if (sel < 85) begin
					cnt = int'($urandom_range(8191));
				end else begin
					cnt = int'($urandom_range(65535));
				end
				if (sel < 85 && $urandom_range(9) == 0)
					cnt += 8192 * int'($urandom_range(7, 1));
				f.encoder = 16'(cnt);
				enc_prev = cnt & 8191;
				f.velocity = 16'($urandom);
				f.current = 16'($urandom);
				f.temp = 8'($urandom);
				offer_frame(f, 1'b0, 0);
			end
		end

		// drain and report
		push <= 1'b0;
		@(posedge clk);
		while (pending_feedback.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
